@@ src/segx_pkg.sv @@
// Shared types for the segment intersection pipeline.
package segx_pkg;

    // Stage control that the top level hands to the divider pipeline.
    typedef struct packed {
        logic en;   // advance every stage by one word
    } t_pipe_ctl;

endpackage

@@ src/segx_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module segx_div #(
    parameter int LOW_W     = 16,
    parameter int FRAC_BITS = 16,
    parameter int DEN_W     = 32,
    parameter int NUM_W     = DEN_W + LOW_W
) (
    input  logic                       i_clk,
    input  segx_pkg::t_pipe_ctl        i_ctl,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic [LOW_W+FRAC_BITS-1:0] o_quot,
    output logic                       o_rem_nz
);

    localparam int S = LOW_W + FRAC_BITS;

    logic [DEN_W-1:0] r_rem [0:S-1];
    logic [DEN_W-1:0] r_den [0:S-1];
    logic [S-1:0]     r_low [0:S-1];
    logic [S-1:0]     r_q   [0:S-1];

    genvar k;
    for (k = 0; k < S; k++) begin : g_st
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [S-1:0]     low_in;
        logic [S-1:0]     q_in;
        logic [DEN_W:0]   cand;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0) begin : g_first
            // High part of the dividend is already below the divisor.
            assign rem_in = i_num[NUM_W-1:LOW_W];
            assign den_in = i_den;
            assign low_in = S'(i_num[LOW_W-1:0]) << FRAC_BITS;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign low_in = r_low[k-1];
            assign q_in   = r_q[k-1];
        end

        assign cand = {rem_in, low_in[S-1]};
        assign diff = cand - {1'b0, den_in};
        assign take = cand >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k] <= take ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
                r_den[k] <= den_in;
                r_low[k] <= low_in << 1;
                r_q[k]   <= {q_in[S-2:0], take};
            end
        end
    end

    assign o_quot   = r_q[S-1];
    assign o_rem_nz = |r_rem[S-1];

endmodule

@@ src/segment_intersection_2d.sv @@
// Top level: streaming 2-D segment intersection test with crossing point.
//
// Slave channel: one word per segment pair, eight signed COORD_BITS fields
// (a_x, a_y, a_dx, a_dy, b_x, b_y, b_dx, b_dy), lowest field first.
// Master channel: one word per input word. tuser carries hit; tdata holds
// cross_x and cross_y, signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero, both zero when there is no hit.
//
// Throughput: one word per cycle while the receiver does not stall. The
// path from accept to output valid runs through the five arithmetic stages
// ahead of the divider, one divider stage per quotient bit, and the output
// register.
//
// Reset clears every valid bit, so the pipeline comes up empty; payload
// registers are not reset. When the receiver stalls with a word on the
// output, the whole pipeline holds and bubbles ahead of the output are not
// squeezed out; s_tready is high only while the output register is empty
// or being taken.
module segment_intersection_2d #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // a_x, a_y, a_dx, a_dy, b_x, b_y, b_dx, b_dy
    input  logic [8*COORD_BITS-1:0]       i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // cross_x, cross_y, zero pad
    output logic [((2*(COORD_BITS+FRAC_BITS+1)+7)/8)*8-1:0] o_m_tdata,
    // hit
    output logic                          o_m_tuser
);

    localparam int C     = COORD_BITS;
    localparam int S     = C + FRAC_BITS;       // quotient bits
    localparam int OUT_W = C + FRAC_BITS + 1;
    localparam int TD_W  = ((2*OUT_W+7)/8)*8;
    localparam int NV    = S + 6;               // valid bits along the pipe

    segx_pkg::t_pipe_ctl ctl;
    logic                en;

    logic [NV-1:0] r_v;

    // Advance everything unless a finished word waits on a stalled receiver.
    assign en         = !r_v[NV-1] || i_m_tready;
    assign ctl.en     = en;
    assign o_s_tready = en;
    assign o_m_tvalid = r_v[NV-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NV-2:0], i_s_tvalid};
        end
    end

    // Unpack the input word.
    logic signed [C-1:0] ax, ay, adx, ady, bx, by, bdx, bdy;
    assign ax  = i_s_tdata[0*C +: C];
    assign ay  = i_s_tdata[1*C +: C];
    assign adx = i_s_tdata[2*C +: C];
    assign ady = i_s_tdata[3*C +: C];
    assign bx  = i_s_tdata[4*C +: C];
    assign by  = i_s_tdata[5*C +: C];
    assign bdx = i_s_tdata[6*C +: C];
    assign bdy = i_s_tdata[7*C +: C];

    // Stage 1: denominator products, start-point offset.
    logic signed [2*C-1:0] r1_pd0, r1_pd1;
    logic signed [C:0]     r1_px, r1_py;
    logic signed [C-1:0]   r1_ax, r1_ay, r1_adx, r1_ady, r1_bdx, r1_bdy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pd0 <= bdx * ady;
            r1_pd1 <= bdy * adx;
            r1_px  <= (C+1)'(ax) - (C+1)'(bx);
            r1_py  <= (C+1)'(ay) - (C+1)'(by);
            r1_ax  <= ax;
            r1_ay  <= ay;
            r1_adx <= adx;
            r1_ady <= ady;
            r1_bdx <= bdx;
            r1_bdy <= bdy;
        end
    end

    // Stage 2: numerator products, denominator difference.
    logic signed [2*C:0]   r2_den;
    logic signed [2*C:0]   r2_t0, r2_t1, r2_u0, r2_u1;
    logic signed [C-1:0]   r2_ax, r2_ay, r2_adx, r2_ady;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_den <= (2*C+1)'(r1_pd0) - (2*C+1)'(r1_pd1);
            r2_t0  <= r1_px * (C+1)'(r1_bdy);
            r2_t1  <= r1_py * (C+1)'(r1_bdx);
            r2_u0  <= r1_px * (C+1)'(r1_ady);
            r2_u1  <= r1_py * (C+1)'(r1_adx);
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_adx <= r1_adx;
            r2_ady <= r1_ady;
        end
    end

    // Stage 3: numerators.
    logic signed [2*C+1:0] r3_den, r3_tn, r3_un;
    logic signed [C-1:0]   r3_ax, r3_ay, r3_adx, r3_ady;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_den <= (2*C+2)'(r2_den);
            r3_tn  <= (2*C+2)'(r2_t0) - (2*C+2)'(r2_t1);
            r3_un  <= (2*C+2)'(r2_u0) - (2*C+2)'(r2_u1);
            r3_ax  <= r2_ax;
            r3_ay  <= r2_ay;
            r3_adx <= r2_adx;
            r3_ady <= r2_ady;
        end
    end

    // Stage 4: make the denominator positive, test the parameter ranges.
    logic signed [2*C+1:0] dn, tnn, unn;
    logic                  hit4;
    assign dn   = r3_den[2*C+1] ? -r3_den : r3_den;
    assign tnn  = r3_den[2*C+1] ? -r3_tn  : r3_tn;
    assign unn  = r3_den[2*C+1] ? -r3_un  : r3_un;
    assign hit4 = (dn != '0) && !tnn[2*C+1] && (tnn <= dn)
               && !unn[2*C+1] && (unn <= dn);

    logic                r4_hit;
    logic [2*C-1:0]      r4_tn, r4_den;
    logic [C-1:0]        r4_magx, r4_magy;
    logic                r4_sx, r4_sy;
    logic signed [C-1:0] r4_ax, r4_ay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_hit  <= hit4;
            r4_tn   <= tnn[2*C-1:0];
            r4_den  <= dn[2*C-1:0];
            r4_magx <= r3_adx[C-1] ? C'(-r3_adx) : C'(r3_adx);
            r4_magy <= r3_ady[C-1] ? C'(-r3_ady) : C'(r3_ady);
            r4_sx   <= r3_adx[C-1];
            r4_sy   <= r3_ady[C-1];
            r4_ax   <= r3_ax;
            r4_ay   <= r3_ay;
        end
    end

    // Stage 5: scale t by each vector magnitude.
    logic [3*C-1:0]      r5_numx, r5_numy;
    logic [2*C-1:0]      r5_den;
    logic                r5_hit, r5_sx, r5_sy;
    logic signed [C-1:0] r5_ax, r5_ay;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_numx <= (3*C)'(r4_tn) * (3*C)'(r4_magx);
            r5_numy <= (3*C)'(r4_tn) * (3*C)'(r4_magy);
            r5_den  <= r4_den;
            r5_hit  <= r4_hit;
            r5_sx   <= r4_sx;
            r5_sy   <= r4_sy;
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
        end
    end

    // Divider pipelines: quotient = num * 2^FRAC_BITS / den.
    logic [S-1:0] qx, qy;
    logic         rx_nz, ry_nz;

    segx_div #(.LOW_W(C), .FRAC_BITS(FRAC_BITS), .DEN_W(2*C)) u_div_x (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_num    (r5_numx),
        .i_den    (r5_den),
        .o_quot   (qx),
        .o_rem_nz (rx_nz)
    );

    segx_div #(.LOW_W(C), .FRAC_BITS(FRAC_BITS), .DEN_W(2*C)) u_div_y (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_num    (r5_numy),
        .i_den    (r5_den),
        .o_quot   (qy),
        .o_rem_nz (ry_nz)
    );

    // Side data travels beside the divider.
    logic                r_mh  [0:S-1];
    logic                r_msx [0:S-1];
    logic                r_msy [0:S-1];
    logic signed [C-1:0] r_max [0:S-1];
    logic signed [C-1:0] r_may [0:S-1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mh[0]  <= r5_hit;
            r_msx[0] <= r5_sx;
            r_msy[0] <= r5_sy;
            r_max[0] <= r5_ax;
            r_may[0] <= r5_ay;
            for (int i = 1; i < S; i++) begin
                r_mh[i]  <= r_mh[i-1];
                r_msx[i] <= r_msx[i-1];
                r_msy[i] <= r_msy[i-1];
                r_max[i] <= r_max[i-1];
                r_may[i] <= r_may[i-1];
            end
        end
    end

    // Output stage: base plus or minus the scaled step, truncated toward zero.
    logic signed [OUT_W-1:0] bx_fx, by_fx, sum_x, sum_y, res_x, res_y;
    assign bx_fx = OUT_W'(r_max[S-1]) <<< FRAC_BITS;
    assign by_fx = OUT_W'(r_may[S-1]) <<< FRAC_BITS;
    assign sum_x = r_msx[S-1] ? bx_fx - OUT_W'(qx) : bx_fx + OUT_W'(qx);
    assign sum_y = r_msy[S-1] ? by_fx - OUT_W'(qy) : by_fx + OUT_W'(qy);

    always_comb begin
        res_x = sum_x;
        if (rx_nz) begin
            if (!r_msx[S-1] && sum_x < 0) begin
                res_x = sum_x + OUT_W'(1);
            end else if (r_msx[S-1] && sum_x > 0) begin
                res_x = sum_x - OUT_W'(1);
            end
        end
        res_y = sum_y;
        if (ry_nz) begin
            if (!r_msy[S-1] && sum_y < 0) begin
                res_y = sum_y + OUT_W'(1);
            end else if (r_msy[S-1] && sum_y > 0) begin
                res_y = sum_y - OUT_W'(1);
            end
        end
    end

    logic                    r_hit;
    logic signed [OUT_W-1:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit <= r_mh[S-1];
            r_cx  <= r_mh[S-1] ? res_x : '0;
            r_cy  <= r_mh[S-1] ? res_y : '0;
        end
    end

    assign o_m_tuser = r_hit;
    assign o_m_tdata = TD_W'({r_cy, r_cx});

endmodule

@@ tb/segx_checker.sv @@
// Checker: watches both channels, predicts each crossing result and compares.
module segx_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [8*COORD_BITS-1:0]       i_s_tdata,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [((2*(COORD_BITS+FRAC_BITS+1)+7)/8)*8-1:0] i_m_tdata,
    input  logic                          i_m_tuser,
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OUT_BITS = COORD_BITS + FRAC_BITS + 1;

    typedef struct {
        logic                hit;
        logic [OUT_BITS-1:0] px;
        logic [OUT_BITS-1:0] py;
    } t_crossing;

    t_crossing crossings_due[$];

    // Exact base + tn*v/d in Q.FRAC_BITS, truncated toward zero.
    function automatic longint fixed_point_on(longint base, longint tn, longint d, longint v);
        longint mag, num, q, r;
        mag = (v < 0) ? -v : v;
        num = tn * mag;             // fits: < 2^31 * 2^16
        q = num / d;
        r = num % d;
        q = (q <<< FRAC_BITS) + (((r <<< FRAC_BITS)) / d);
        r = (r <<< FRAC_BITS) % d;
        if (v >= 0) begin
            fixed_point_on = (base <<< FRAC_BITS) + q;
            if (fixed_point_on < 0 && r != 0) fixed_point_on += 1;
        end else begin
            fixed_point_on = (base <<< FRAC_BITS) - q;
            if (fixed_point_on > 0 && r != 0) fixed_point_on -= 1;
        end
    endfunction

    function automatic t_crossing predict_crossing(logic [8*COORD_BITS-1:0] w);
        longint f [8];
        longint den, tn, un, px, py;
        t_crossing c;
        for (int i = 0; i < 8; i++)
            f[i] = longint'($signed(w[i*COORD_BITS +: COORD_BITS]));
        den = f[6] * f[3] - f[7] * f[2];
        px = f[0] - f[4];
        py = f[1] - f[5];
        tn = px * f[7] - py * f[6];
        un = px * f[3] - py * f[2];
        if (den < 0) begin
            den = -den; tn = -tn; un = -un;
        end
        c.hit = den != 0 && tn >= 0 && tn <= den && un >= 0 && un <= den;
        c.px = '0;
        c.py = '0;
        if (c.hit) begin
            c.px = OUT_BITS'(fixed_point_on(f[0], tn, den, f[2]));
            c.py = OUT_BITS'(fixed_point_on(f[1], tn, den, f[3]));
        end
        return c;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_hits = 0;
    end

    assign o_pending = crossings_due.size();

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && i_s_tvalid && i_s_tready)
            crossings_due.push_back(predict_crossing(i_s_tdata));
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            if (crossings_due.size() == 0) begin
                report("unexpected word", i_m_tuser, 0);
            end else begin
                want = crossings_due.pop_front();
                if (want.hit) o_hits++;
                if (i_m_tuser !== want.hit) report("hit", i_m_tuser, want.hit);
                if (i_m_tdata[OUT_BITS-1:0] !== want.px)
                    report("cross_x", i_m_tdata[OUT_BITS-1:0], want.px);
                if (i_m_tdata[OUT_BITS +: OUT_BITS] !== want.py)
                    report("cross_y", i_m_tdata[OUT_BITS +: OUT_BITS], want.py);
            end
        end
    end
endmodule

@@ tb/tb.sv @@
// Testbench top: drives segment pairs, randomizes backpressure, gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = 16;
    localparam int FB = 16;
    localparam int DW = ((2*(CB+FB+1)+7)/8)*8;
    localparam int LATENCY = CB + FB + 6;
    localparam int N_RANDOM = 1000;
    localparam int CYCLE_LIMIT = 400000;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [8*CB-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [DW-1:0]   m_tdata;
    logic            m_tuser;
    int              errors, pending, hits;
    int              n_sent = 0;
    int              cycles = 0;
    int              rx_hold = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    segment_intersection_2d #(.COORD_BITS(CB), .FRAC_BITS(FB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser)
    );

    segx_checker #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser),
        .o_errors(errors), .o_pending(pending), .o_hits(hits)
    );

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Receiver: ready now and then, with stalls of random length in between.
    always @(posedge i_clk) begin
        int g;
        if (i_rst_n) begin
            if (rx_hold > 0) begin
                rx_hold  <= rx_hold - 1;
                m_tready <= 1'b0;
            end else begin
                g = gap_len();
                m_tready <= (g == 0);
                rx_hold  <= (g > 0) ? g - 1 : 0;
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[segment_intersection_2d] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] rnd_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'h8000;
        if (r == 1) return 16'h7fff;
        if (r < 6) return 16'($urandom_range(0, 200)) - 16'd100;   // dense, likely crossing
        return 16'($urandom);
    endfunction

    // Build a pair: mostly crossing-prone geometry, some parallel, some raw noise.
    function automatic logic [8*CB-1:0] random_pair();
        logic [15:0] f [8];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 8; i++) f[i] = rnd_coord();
        if (kind < 5) begin
            // B starts near A's midpoint side, pointing across it
            f[4] = f[0] + f[2] / 2 - f[7];
            f[5] = f[1] + f[3] / 2 + f[6];
        end else if (kind < 7) begin
            // parallel or collinear: vB a multiple of vA
            f[6] = f[2] * 2;
            f[7] = f[3] * 2;
            if (kind == 6) begin f[4] = f[0] - f[2]; f[5] = f[1] - f[3]; end
        end else if (kind == 7) begin
            for (int i = 0; i < 8; i++) f[i] = 16'($urandom);
        end
        return {f[7], f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
    endfunction

    task automatic send_pair(logic [8*CB-1:0] w);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
    endtask

    function automatic logic [8*CB-1:0] pack(int ax, int ay, int adx, int ady,
                                             int bx, int by, int bdx, int bdy);
        return {16'(bdy), 16'(bdx), 16'(by), 16'(bx), 16'(ady), 16'(adx), 16'(ay), 16'(ax)};
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: plain crossing, endpoint touches, parallel, collinear, extremes.
        send_pair(pack(0, 0, 10, 10, 0, 10, 10, -10));
        send_pair(pack(0, 0, 10, 0, 10, -5, 0, 10));        // touch at t = 1
        send_pair(pack(0, 0, 10, 0, 0, -5, 0, 10));         // touch at t = 0
        send_pair(pack(0, 0, 10, 0, 5, 0, 0, 10));          // touch at u = 0
        send_pair(pack(0, 0, 10, 0, 5, -10, 0, 10));        // touch at u = 1
        send_pair(pack(0, 0, 10, 0, 0, 5, 10, 0));          // parallel
        send_pair(pack(0, 0, 10, 10, 20, 20, 5, 5));        // collinear
        send_pair(pack(0, 0, 10, 0, 20, -5, 0, 10));        // miss
        send_pair(pack(0, 0, 0, 0, 0, 0, 0, 0));            // degenerate
        send_pair(pack(0, 0, 3, 1, 1, 1, 0, -3));           // fractional point
        send_pair(pack(0, 0, -3, -1, -1, -1, 0, 3));        // negative fraction
        send_pair(pack(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(pack(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
        send_pair(pack(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
        send_pair(pack(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        send_pair({8{16'hffff}});
        send_pair({8{16'h5555}});
        send_pair({8{16'haaaa}});

        // Drain completely once before the random part.
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        for (int k = 0; k < N_RANDOM; k++) begin
            send_pair(random_pair());
            if (k == N_RANDOM / 2) begin
                s_tvalid <= 1'b0;
                while (pending != 0) @(posedge i_clk);
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("sent %0d segment pairs, %0d of them crossing, with random stalls on both sides",
                 n_sent, hits);
        if (errors == 0) begin
            $display("[segment_intersection_2d] OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("[segment_intersection_2d] ERROR");
        end
        $finish;
    end
endmodule

@@ files.f @@
src/segx_pkg.sv
src/segx_div.sv
src/segment_intersection_2d.sv
tb/segx_checker.sv
tb/tb.sv
